// ===== rtl/top_k_latest_by_timestamp_assert.svh =====
// Assertion macros for the top-k newest record block.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef TOP_K_LATEST_BY_TIMESTAMP_ASSERT_SVH
`define TOP_K_LATEST_BY_TIMESTAMP_ASSERT_SVH

`ifndef SYNTH
`define TKL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TKL_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TKL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/tkl_pkg.sv =====
// Shared types and constants for the top-k newest record block.
// Used by the cell, the chain and the top level; depends on nothing.
`timescale 1ns / 1ps

package tkl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int STAMP_W = 64;
  localparam int INDEX_W = 64;
  localparam int HANDLE_W = 32;
  localparam int KEEP_W = 7;
  localparam int DATA_W = STAMP_W + INDEX_W + HANDLE_W;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // The stamp sits in the lowest bits, matching the word layout.
  typedef struct packed {
    logic [HANDLE_W-1:0]       handle;
    logic [INDEX_W-1:0]        event_index;
    logic signed [STAMP_W-1:0] stamp;
  } rec_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_DOWN,
    OP_INSERT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_INSERT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    cell_op_t op;
    rec_t     item;
  } chain_ctrl_t;

endpackage

// ===== rtl/tkl_cell.sv =====
// One storage cell of the sorted record chain.
// Depends on tkl_pkg for the record and control types.
`timescale 1ns / 1ps

module tkl_cell import tkl_pkg::*; (
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  logic        occ,
  input  logic        prev_occ,
  input  logic        prev_gt,
  input  rec_t        prev_rec,
  input  rec_t        next_rec,
  output rec_t        rec,
  output logic        gt
);

  rec_t rec_next;

  assign gt = occ && ($signed(rec.stamp) > $signed(ctrl.item.stamp));

  // On insert, cells above the insertion point move up by one and the first
  // cell that is empty or newer than the item takes the item.
  always_comb begin
    rec_next = rec;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (prev_occ && prev_gt) begin
          rec_next = prev_rec;
        end else if (prev_occ && (gt || !occ)) begin
          rec_next = ctrl.item;
        end
      end
      OP_SHIFT_DOWN: begin
        rec_next = next_rec;
      end
      default: begin
        rec_next = rec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// ===== rtl/tkl_chain.sv =====
// Row of tkl_cell instances kept sorted by ascending stamp, oldest at cell 0.
// Depends on tkl_pkg and tkl_cell.
`timescale 1ns / 1ps

module tkl_chain import tkl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  chain_ctrl_t         ctrl,
  input  logic [CAPACITY-1:0] occ,
  output rec_t                head
);

  rec_t recs [CAPACITY];
  logic [CAPACITY-1:0] gts;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic p_occ;
    logic p_gt;
    rec_t p_rec;
    rec_t n_rec;

    if (i == 0) begin : g_first
      assign p_occ = 1'b1;
      assign p_gt = 1'b0;
      assign p_rec = '0;
    end else begin : g_mid
      assign p_occ = occ[i-1];
      assign p_gt = gts[i-1];
      assign p_rec = recs[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign n_rec = '0;
    end else begin : g_inner
      assign n_rec = recs[i+1];
    end

    tkl_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (occ[i]),
      .prev_occ (p_occ),
      .prev_gt  (p_gt),
      .prev_rec (p_rec),
      .next_rec (n_rec),
      .rec      (recs[i]),
      .gt       (gts[i])
    );
  end

  assign head = recs[0];

endmodule

// ===== rtl/top_k_latest_by_timestamp.sv =====
// Add: accepted in ST_IDLE and stored in ST_INSERT; when the store is full, ST_EVICT first
// drops the oldest record, and an add whose stamp is not newer than the oldest is dropped.
// Flush: one word per cycle, while the output register is free, from the chain head into it;
// an empty flush gives one word. The cell chain does at most one shift or insert per cycle.
// Synchronous active-high reset empties the store, sets max_keep to 64 and
// drops any pending output word; record storage itself is not cleared.
`timescale 1ns / 1ps
`include "top_k_latest_by_timestamp_assert.svh"

module top_k_latest_by_timestamp import tkl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // stamp, event_index, record_handle
  input  logic [0:0]        s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // out_stamp, out_event_index, out_handle
  output logic [0:0]        m_axis_tuser,  // valid_res
  output logic              m_axis_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KEEP_W-1:0] cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [KEEP_W-1:0] CAP_K = KEEP_W'(CAPACITY);
  localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);

  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [KEEP_W-1:0] max_keep;
  rec_t              item;
  logic              out_valid;
  rec_t              out_rec;
  logic              out_flag;
  logic              out_last;

  chain_ctrl_t         ctrl;
  rec_t                head;
  rec_t                in_rec;
  logic [CAPACITY-1:0] occ;
  logic [KEEP_W-1:0]   limit;
  logic                accept;
  logic                can_fill;
  logic                beats_min;
  logic                out_free;
  logic                emit;

  tkl_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .occ  (occ),
    .head (head)
  );

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = count > CW'(i);
    end
  end

  assign in_rec = rec_t'(s_axis_tdata);
  assign limit = (max_keep > CAP_K) ? CAP_K : max_keep;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign can_fill = KEEP_W'(count) < limit;
  assign beats_min = (count != '0) && ($signed(in_rec.stamp) > $signed(head.stamp));
  assign out_free = !out_valid || m_axis_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser[0] == KIND_FLUSH) begin
            state_next = ST_FLUSH;
          end else if (can_fill) begin
            state_next = ST_INSERT;
          end else if (beats_min) begin
            state_next = ST_EVICT;
          end
        end
      end
      ST_EVICT: state_next = ST_INSERT;
      ST_INSERT: state_next = ST_IDLE;
      ST_FLUSH: begin
        if (out_free && (count <= CW'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctrl.op = OP_HOLD;
    ctrl.item = item;
    emit = 1'b0;
    count_next = count;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_EVICT: begin
        ctrl.op = OP_SHIFT_DOWN;
        count_next = count - CW'(1);
      end
      ST_INSERT: begin
        ctrl.op = OP_INSERT;
        count_next = count + CW'(1);
      end
      ST_FLUSH: begin
        emit = out_free;
        if (out_free && (count != '0)) begin
          ctrl.op = OP_SHIFT_DOWN;
          count_next = count - CW'(1);
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      max_keep <= KEEP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        max_keep <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_rec;
    end
    if (emit) begin
      out_rec <= (count != '0) ? head : '0;
      out_flag <= count != '0;
      out_last <= count <= CW'(1);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_rec;
  assign m_axis_tuser = out_flag;
  assign m_axis_tlast = out_last;

  `TKL_ASSERT_IMPLY(a_count_cap, 1'b1, count <= CNT_MAX, "kept count exceeds capacity")
  `TKL_ASSERT_NEXT(a_insert_grows, state == ST_INSERT,
                   count == $past(count) + CW'(1), "insert did not grow the store")
  `TKL_ASSERT_NEXT(a_flush_ends, emit && (count == CW'(1)),
                   (count == '0) && (state == ST_IDLE), "flush did not empty the store")

endmodule
